// ===== rtl/signed_int_to_decimal_ascii_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the signed integer to ASCII block.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SIDTA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication, checked out of reset
`define SIDTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/sidta_pkg.sv =====
// ----------------------------------------------------------------------------
// sidta_pkg
// Widths and character codes for the signed integer to ASCII block.
// ----------------------------------------------------------------------------
package sidta_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DIGITS      = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int BCD_W       = 4 * DIGITS;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CHAR_W      = 6;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);

  typedef logic [VALUE_WIDTH-1:0] mag_t;
  typedef logic [BCD_W-1:0]       bcd_t;

  typedef struct packed {
    logic load;
    mag_t mag;
  } dab_ctl_t;

  typedef struct packed {
    logic run;
    logic done;
  } dab_sts_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer into its decimal ASCII text, one character a beat.
// ----------------------------------------------------------------------------
// Input: drive in_value and raise start; the beat is taken on a rising edge
// with start high and busy low. busy stays high until the last character
// has been put on the result ports.
// Output: each character is on out_char_code for exactly one cycle with
// out_valid high; a minus sign comes first for negative values, then the
// digits without leading zeros, most significant first. out_last marks the
// final character. The receiver cannot stall; every strobed beat is taken.
// Conversion: the shift-and-add-3 unit takes one magnitude bit per cycle; once it
// is done, the sign if any and then the digits follow one per cycle.
// Next value: a new value is taken in the cycle the last character is shown;
// none is taken while busy is high.
// Reset: rst_n low clears the sequencer and the strobe; any run in progress
// is dropped.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii
  import sidta_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                    out_valid,
  output logic [CHAR_W-1:0]       out_char_code,
  output logic                    out_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_DIGIT
  } state_t;

  state_t           state_r,  state_nxt;
  logic             neg_r,    neg_nxt;
  logic [IDX_W-1:0] idx_r,    idx_nxt;
  logic             valid_r,  valid_nxt;
  logic [CHAR_W-1:0] char_r,  char_nxt;
  logic             last_r,   last_nxt;

  dab_ctl_t   dab_ctl;
  dab_sts_t   dab_sts;
  bcd_t       bcd;
  mag_t       vin;
  logic [IDX_W-1:0] top_idx;
  logic [3:0] digit;

  assign vin = $unsigned(in_value);

  always_comb begin
    dab_ctl.load = (state_r == S_IDLE) && start;
    dab_ctl.mag  = vin[VALUE_WIDTH-1] ? (~vin + VALUE_WIDTH'(1)) : vin;
  end

  sidta_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dab_ctl),
    .sts   (dab_sts),
    .bcd   (bcd)
  );

  always_comb begin
    top_idx = '0;
    for (int k = 0; k < DIGITS; k++) begin
      if (bcd[4*k +: 4] != 4'd0) begin
        top_idx = IDX_W'(k);
      end
    end
  end

  assign digit = bcd[idx_r*4 +: 4];

  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    idx_nxt   = idx_r;
    valid_nxt = 1'b0;
    char_nxt  = char_r;
    last_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_nxt   = vin[VALUE_WIDTH-1];
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (dab_sts.done) begin
          idx_nxt   = top_idx;
          state_nxt = neg_r ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        valid_nxt = 1'b1;
        char_nxt  = CHAR_MINUS;
        state_nxt = S_DIGIT;
      end
      S_DIGIT: begin
        valid_nxt = 1'b1;
        char_nxt  = CHAR_ZERO + {2'b00, digit};
        if (idx_r == '0) begin
          last_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
    neg_r  <= neg_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = valid_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;

  `SIDTA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `SIDTA_ASSERT_NEXT(a_last_gap, clk, rst_n, out_valid && out_last, !out_valid)
  `SIDTA_ASSERT_NEXT(a_sign_then_digit, clk, rst_n,
    out_valid && (out_char_code == CHAR_MINUS),
    out_valid && (out_char_code != CHAR_MINUS))
  `SIDTA_ASSERT_NOW(a_done_in_conv, clk, rst_n, dab_sts.done, state_r == S_CONV)
  `SIDTA_ASSERT_NOW(a_run_in_conv, clk, rst_n, dab_sts.run, state_r == S_CONV)

endmodule

// ===== rtl/sidta_dabble.sv =====
// ----------------------------------------------------------------------------
// sidta_dabble
// Shift-and-add-3 unit: one magnitude bit per cycle into a BCD register.
// ----------------------------------------------------------------------------
module sidta_dabble
  import sidta_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dab_ctl_t ctl,
  output dab_sts_t sts,
  output bcd_t     bcd
);

  mag_t             mag_r;
  bcd_t             bcd_r;
  bcd_t             adj;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_r[4*k +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.load) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(VALUE_WIDTH);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag_r <= ctl.mag;
      bcd_r <= '0;
    end else if (run_r) begin
      mag_r <= {mag_r[VALUE_WIDTH-2:0], 1'b0};
      bcd_r <= {adj[BCD_W-2:0], mag_r[VALUE_WIDTH-1]};
    end
  end

  assign sts.run  = run_r;
  assign sts.done = done_r;
  assign bcd      = bcd_r;

endmodule

// ===== bench/tb_signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Sends signed integers into the converter, directed edge values first and
// then random ones, with random gaps before some commands. For each accepted
// value the bench queues the expected ASCII characters and checks every
// strobed character beat, in order, against them.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii
  import sidta_pkg::*;
;

  localparam int NUM_DIRECTED = 21;
  localparam int NUM_RANDOM   = 80;
  localparam int CALM_TAIL    = 20;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int SETTLE       = 3 * VALUE_WIDTH;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_beat_t;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] value;
    string                         text;
  } dec_vector_t;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic signed [VALUE_WIDTH-1:0] in_value;
  logic                          out_valid;
  logic [CHAR_W-1:0]             out_char_code;
  logic                          out_last;

  char_beat_t  pending_chars[$];
  int          fail_count;
  dec_vector_t dec_vectors[NUM_DIRECTED];

  signed_int_to_decimal_ascii DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic push_char(input logic [CHAR_W-1:0] code, input logic last);
    char_beat_t b;
    b.code = code;
    b.last = last;
    pending_chars.push_back(b);
  endtask

  task automatic push_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      push_char(CHAR_W'(text[i]), i == text.len() - 1);
    end
  endtask

  // Convert the unsigned magnitude so the most negative value is exact.
  task automatic predict_chars(input logic signed [VALUE_WIDTH-1:0] v);
    mag_t              mag;
    logic [CHAR_W-1:0] digits[$];
    mag = v[VALUE_WIDTH-1] ? mag_t'(~v + 1'b1) : mag_t'(v);
    do begin
      digits.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (v[VALUE_WIDTH-1]) begin
      push_char(CHAR_MINUS, 1'b0);
    end
    foreach (digits[i]) begin
      push_char(digits[i], i == digits.size() - 1);
    end
  endtask

  // Hold start and the value until the beat is taken.
  task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v, input string text);
    in_value = v;
    start    = 1'b1;
    do @(posedge clk); while (busy);
    if (text.len() == 0) begin
      predict_chars(v);
    end else begin
      push_text(text);
    end
    @(negedge clk);
  endtask

  task automatic idle_burst(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic signed [VALUE_WIDTH-1:0] random_value();
    longint                        p;
    logic signed [VALUE_WIDTH-1:0] v;
    p = 1;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, VALUE_WIDTH - 1);
      2: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = VALUE_WIDTH'(p + $urandom_range(0, 2) - 1);
      end
      default: v = VALUE_WIDTH'($urandom_range(0, 20));
    endcase
    if ($urandom_range(0, 1)) begin
      v = -v;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    char_beat_t exp_beat;
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        $error("out_char_code: unexpected beat, got %0d", out_char_code);
        fail_count++;
      end else begin
        exp_beat = pending_chars.pop_front();
        if (out_char_code !== exp_beat.code) begin
          $error("out_char_code: expected %0d, got %0d", exp_beat.code, out_char_code);
          fail_count++;
        end
        if (out_last !== exp_beat.last) begin
          $error("out_last: expected %0d, got %0d", exp_beat.last, out_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int waited;
    fail_count = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_value   = '0;
    dec_vectors = '{
      '{value: 32'sd0,          text: "0"},
      '{value: -32'sd1,         text: "-1"},
      '{value: 32'h7fff_ffff,   text: "2147483647"},
      '{value: 32'h8000_0000,   text: "-2147483648"},
      '{value: 32'sd1,          text: ""},
      '{value: 32'sd9,          text: ""},
      '{value: 32'sd10,         text: ""},
      '{value: -32'sd10,        text: ""},
      '{value: 32'sd99,         text: ""},
      '{value: 32'sd100,        text: ""},
      '{value: -32'sd2147483647, text: ""},
      '{value: 32'sd1000000000, text: ""},
      '{value: 32'sd999999999,  text: ""},
      '{value: -32'sd999999999, text: ""},
      '{value: 32'sd1999999999, text: ""},
      '{value: -32'sd7,         text: ""},
      '{value: 32'sd12345,      text: ""},
      '{value: -32'sd54321,     text: ""},
      '{value: 32'h5555_5555,   text: ""},
      '{value: 32'haaaa_aaaa,   text: ""},
      '{value: 32'sd1234567890, text: ""}
    };
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dec_vectors[i]) begin
      if ($urandom_range(0, 2) == 0) begin
        idle_burst($urandom_range(1, 9));
      end
      send_value(dec_vectors[i].value, dec_vectors[i].text);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 2) == 0) begin
        idle_burst($urandom_range(1, 9));
      end
      send_value(random_value(), "");
    end
    start = 1'b0;

    waited = 0;
    while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $error("out_char_code: %0d expected beats never arrived", pending_chars.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
